### hdl/dnta_pkg.sv
// Shared types and constants for the decimal-to-ASCII printer.
`default_nettype none

package dnta_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int IN_TDATA_W = 64;
  localparam int OUT_TDATA_W = 8;
  localparam int CHAR_W = 6;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_NINE = 6'd57;

  typedef enum logic [1:0] {
    CONV_IDLE,
    CONV_SHIFT,
    CONV_PUSH
  } conv_state_t;

  typedef enum logic {
    EMIT_IDLE,
    EMIT_RUN
  } emit_state_t;

endpackage

`default_nettype wire

### hdl/dnta_conv.sv
// Front end: accepts a value and converts it to packed BCD by shift-and-add-3.
`default_nettype none

module dnta_conv
  import dnta_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int NUM_DIGITS  = 20
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [IN_TDATA_W-1:0]     value,
  input  wire logic                      value_valid,
  output logic                           value_ready,
  output logic [4*NUM_DIGITS-1:0]        bcd_data,
  output logic                           bcd_valid,
  input  wire logic                      bcd_ready
);

  localparam int BW = 4 * NUM_DIGITS;
  localparam int CW = $clog2(VALUE_WIDTH);

  conv_state_t state, state_next;
  logic [VALUE_WIDTH-1:0] sh;
  logic [BW-1:0] bcd;
  logic [BW-1:0] adj;
  logic [CW-1:0] cnt;

  // Every digit of five or more gets three added before the doubling shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_comb begin
    state_next  = state;
    value_ready = 1'b0;
    bcd_valid   = 1'b0;
    unique case (state)
      CONV_IDLE: begin
        value_ready = 1'b1;
        if (value_valid) begin
          state_next = CONV_SHIFT;
        end
      end
      CONV_SHIFT: begin
        if (cnt == '0) begin
          state_next = CONV_PUSH;
        end
      end
      CONV_PUSH: begin
        bcd_valid = 1'b1;
        if (bcd_ready) begin
          state_next = CONV_IDLE;
        end
      end
      default: state_next = CONV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CONV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == CONV_IDLE && value_valid) begin
      sh  <= value[VALUE_WIDTH-1:0];
      bcd <= '0;
      cnt <= CW'(VALUE_WIDTH - 1);
    end else if (state == CONV_SHIFT) begin
      sh  <= {sh[VALUE_WIDTH-2:0], 1'b0};
      bcd <= {adj[BW-2:0], sh[VALUE_WIDTH-1]};
      cnt <= cnt - 1'b1;
    end
  end

  assign bcd_data = bcd;

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state != CONV_IDLE) |-> !value_ready)
    else $error("front end ready while a conversion is in progress");

  a_push_after_shift: assert property (@(posedge clk) disable iff (rst)
    $rose(bcd_valid) |-> $past(state == CONV_SHIFT && cnt == '0))
    else $error("BCD word offered before all bits were shifted in");

endmodule

`default_nettype wire

### hdl/dnta_queue.sv
// Small queue that decouples the converter from the digit emitter.
`default_nettype none

module dnta_queue
  import dnta_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF,
  parameter int WIDTH = 80
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  rd_valid,
  input  wire logic             rd_ready
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [NW-1:0] cnt;
  logic do_wr, do_rd;

  assign wr_ready = (cnt != NW'(DEPTH));
  assign rd_valid = (cnt != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt <= cnt + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= NW'(DEPTH))
    else $error("queue fill count beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (cnt == '0 || cnt == NW'(DEPTH)) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

### hdl/dnta_emit.sv
// Back end: walks a BCD word from the top digit, skips leading zeros, sends characters.
`default_nettype none

module dnta_emit
  import dnta_pkg::*;
#(
  parameter int NUM_DIGITS = 20
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [4*NUM_DIGITS-1:0] bcd_data,
  input  wire logic                   bcd_valid,
  output logic                        bcd_ready,
  output logic [CHAR_W-1:0]           digit_char,
  output logic                        last,
  output logic                        char_valid,
  input  wire logic                   char_ready
);

  localparam int BW = 4 * NUM_DIGITS;
  localparam int IW = $clog2(NUM_DIGITS);

  emit_state_t state, state_next;
  logic [BW-1:0] bcd;
  logic [IW-1:0] idx;
  logic started;
  logic [3:0] top;
  logic show, slot_free, step, load;

  assign top       = bcd[BW-1 -: 4];
  // The units digit is always sent, so a zero value still yields one character.
  assign show      = started || (top != 4'd0) || (idx == '0);
  assign slot_free = !char_valid || char_ready;
  assign step      = (state == EMIT_RUN) && (!show || slot_free);
  assign load      = step && show;

  always_comb begin
    state_next = state;
    bcd_ready  = 1'b0;
    unique case (state)
      EMIT_IDLE: begin
        bcd_ready = 1'b1;
        if (bcd_valid) begin
          state_next = EMIT_RUN;
        end
      end
      EMIT_RUN: begin
        if (step && idx == '0) begin
          state_next = EMIT_IDLE;
        end
      end
      default: state_next = EMIT_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= EMIT_IDLE;
      char_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        char_valid <= 1'b1;
      end else if (char_ready) begin
        char_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == EMIT_IDLE && bcd_valid) begin
      bcd     <= bcd_data;
      idx     <= IW'(NUM_DIGITS - 1);
      started <= 1'b0;
    end else if (step) begin
      bcd     <= {bcd[BW-5:0], 4'd0};
      idx     <= idx - 1'b1;
      started <= started || show;
    end
    if (load) begin
      digit_char <= ASCII_ZERO + CHAR_W'(top);
      last       <= (idx == '0);
    end
  end

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> (digit_char >= ASCII_ZERO && digit_char <= ASCII_NINE))
    else $error("character outside the decimal digits");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (load && idx == '0) |=> (state == EMIT_IDLE && last))
    else $error("units digit did not close the run");

endmodule

`default_nettype wire

### hdl/decimal_number_to_ascii.sv
// Top level: prints an unsigned number as a run of ASCII decimal digits.
//
//  Port group   Dir  Beat contents
//  s_axis_*     in   tdata[63:0] = value (low VALUE_WIDTH bits used)
//  m_axis_*     out  tdata[5:0] = digit_char, tdata[7:6] = 0; tlast = last
//
// The converter takes one value at a time, which its one-bit-per-cycle shift-and-add-3 loop
// turns into BCD; it is ready again in the cycle after its result enters the queue.
// The emitter loads a BCD word, then steps through every digit position (20 at VALUE_WIDTH = 64,
// zeros included) and sends one character per cycle when the output is not stalled.
// A stalled output fills the queue before the input side stops accepting.
// Synchronous reset clears FSM, queue and valid state; no clearing pass is needed.
`default_nettype none

module decimal_number_to_ascii
  import dnta_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [63:0] value
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // [5:0] digit_char, [7:6] zero
  output logic                        m_axis_tlast
);

  // Digits of 2^VALUE_WIDTH - 1: floor(VALUE_WIDTH * log10(2)) + 1.
  localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BW = 4 * NUM_DIGITS;

  logic [BW-1:0] c_data, q_data;
  logic c_valid, c_ready, q_valid, q_ready;
  logic [CHAR_W-1:0] digit_char;

  dnta_conv #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NUM_DIGITS  (NUM_DIGITS)
  ) u_conv (
    .clk         (clk),
    .rst         (rst),
    .value       (s_axis_tdata),
    .value_valid (s_axis_tvalid),
    .value_ready (s_axis_tready),
    .bcd_data    (c_data),
    .bcd_valid   (c_valid),
    .bcd_ready   (c_ready)
  );

  dnta_queue #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (BW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_data  (c_data),
    .wr_valid (c_valid),
    .wr_ready (c_ready),
    .rd_data  (q_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  dnta_emit #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .bcd_data   (q_data),
    .bcd_valid  (q_valid),
    .bcd_ready  (q_ready),
    .digit_char (digit_char),
    .last       (m_axis_tlast),
    .char_valid (m_axis_tvalid),
    .char_ready (m_axis_tready)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - CHAR_W)'(0), digit_char};

endmodule

`default_nettype wire
